>>> design/ipfl_pkg.sv
`default_nettype none
package ipfl_pkg;

  localparam int DEF_NUM_POOLS  = 4;
  localparam int DEF_POOL_SLOTS = 64;
  localparam int RESET_CAPACITY = 64;

  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_TYPES    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY = 1'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC       = 2'd0,
    REQ_RELEASE     = 2'd1,
    REQ_RELEASE_ALL = 2'd2,
    REQ_QUERY       = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_BAD_TYPE   = 3'd1,
    ST_EXHAUSTED  = 3'd2,
    ST_RANGE      = 3'd3,
    ST_NOT_ACTIVE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_GRANT,
    S_WALK
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    pop;
    logic    release_one;
    logic    walk_init;
    logic    walk_step;
    logic    grant;
    logic    emit;
    status_t emit_status;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_t req;
    logic bad_type;
    logic empty;
    logic out_of_range;
    logic slot_active;
    logic walk_last;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> design/ipfl_ram.sv
`default_nettype none
module ipfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/ipfl_controller.sv
`default_nettype none
module ipfl_controller (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire ipfl_pkg::dp_stat_t stat,
  output ipfl_pkg::ctl_cmd_t      cmd,
  output logic                    busy
);

  ipfl_pkg::state_t state;
  ipfl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipfl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ipfl_pkg::S_IDLE: begin
        if (start) begin
          state_next = ipfl_pkg::S_EXEC;
        end
      end
      ipfl_pkg::S_EXEC: begin
        if (stat.bad_type) begin
          state_next = ipfl_pkg::S_IDLE;
        end else if (stat.req == ipfl_pkg::REQ_ALLOC && !stat.empty) begin
          state_next = ipfl_pkg::S_GRANT;
        end else if (stat.req == ipfl_pkg::REQ_RELEASE_ALL) begin
          state_next = ipfl_pkg::S_WALK;
        end else begin
          state_next = ipfl_pkg::S_IDLE;
        end
      end
      ipfl_pkg::S_GRANT: begin
        state_next = ipfl_pkg::S_IDLE;
      end
      ipfl_pkg::S_WALK: begin
        if (stat.walk_last) begin
          state_next = ipfl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ipfl_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.emit_status = ipfl_pkg::ST_OK;
    busy            = 1'b1;
    case (state)
      ipfl_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ipfl_pkg::S_EXEC: begin
        if (stat.bad_type) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ipfl_pkg::ST_BAD_TYPE;
        end else begin
          case (stat.req)
            ipfl_pkg::REQ_ALLOC: begin
              if (stat.empty) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ipfl_pkg::ST_EXHAUSTED;
              end else begin
                cmd.pop = 1'b1;
              end
            end
            ipfl_pkg::REQ_RELEASE: begin
              cmd.emit = 1'b1;
              if (stat.out_of_range) begin
                cmd.emit_status = ipfl_pkg::ST_RANGE;
              end else if (!stat.slot_active) begin
                cmd.emit_status = ipfl_pkg::ST_NOT_ACTIVE;
              end else begin
                cmd.release_one = 1'b1;
              end
            end
            ipfl_pkg::REQ_RELEASE_ALL: begin
              cmd.walk_init = 1'b1;
            end
            ipfl_pkg::REQ_QUERY: begin
              cmd.emit = 1'b1;
            end
            default: begin
              cmd.emit = 1'b1;
            end
          endcase
        end
      end
      ipfl_pkg::S_GRANT: begin
        cmd.grant = 1'b1;
        cmd.emit  = 1'b1;
      end
      ipfl_pkg::S_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.emit      = stat.walk_last;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> design/ipfl_datapath.sv
`default_nettype none
module ipfl_datapath #(
  parameter  int NUM_POOLS  = ipfl_pkg::DEF_NUM_POOLS,
  parameter  int POOL_SLOTS = ipfl_pkg::DEF_POOL_SLOTS,
  localparam int SLOT_W     = $clog2(POOL_SLOTS),
  localparam int CAP_W      = $clog2(POOL_SLOTS + 1),
  localparam int TID_W      = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1,
  localparam int TYPES_W    = $clog2(NUM_POOLS + 1),
  localparam int CFG_W      = (TYPES_W > CAP_W) ? TYPES_W : CAP_W
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  input  wire logic [ipfl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]                     cfg_data,
  input  wire logic [ipfl_pkg::REQ_W-1:0]           req_type,
  input  wire logic [TID_W-1:0]                     type_id,
  input  wire logic [SLOT_W-1:0]                    slot_index,
  input  wire ipfl_pkg::ctl_cmd_t                   cmd,
  output ipfl_pkg::dp_stat_t                        stat,
  output logic                                      done,
  output logic [ipfl_pkg::STATUS_W-1:0]             status,
  output logic [SLOT_W-1:0]                         granted_index,
  output logic [CAP_W-1:0]                          active_count
);

  localparam int ADDR_W  = TID_W + SLOT_W;
  localparam int INIT_CAP_I = (ipfl_pkg::RESET_CAPACITY > POOL_SLOTS) ?
                              POOL_SLOTS : ipfl_pkg::RESET_CAPACITY;
  localparam logic [CAP_W-1:0]   INIT_CAP  = CAP_W'(INIT_CAP_I);
  localparam logic [CAP_W-1:0]   MAX_CAP   = CAP_W'(POOL_SLOTS);
  localparam logic [TYPES_W-1:0] MAX_TYPES = TYPES_W'(NUM_POOLS);

  // control state
  logic [TYPES_W-1:0]    types_defined;
  logic [CAP_W-1:0]      capacity;
  logic [CAP_W-1:0]      depth     [NUM_POOLS];
  // stack entries below low_mark were never overwritten and still hold their index
  logic [CAP_W-1:0]      low_mark  [NUM_POOLS];
  logic [POOL_SLOTS-1:0] active_map[NUM_POOLS];

  // payload
  logic [ipfl_pkg::REQ_W-1:0] req_q;
  logic [TID_W-1:0]           tid_q;
  logic [SLOT_W-1:0]          slot_q;
  logic [SLOT_W-1:0]          walk_k;
  logic                       pop_init;

  logic [CAP_W-1:0]   d;
  logic [CAP_W-1:0]   d_minus;
  logic [CAP_W-1:0]   depth_sel_next;
  logic [CAP_W-1:0]   count_next;
  logic               push_en;
  logic [SLOT_W-1:0]  push_idx;
  logic [SLOT_W-1:0]  ram_rdata;
  logic [SLOT_W-1:0]  granted_val;
  logic [CAP_W-1:0]   cap_raw;
  logic [CAP_W-1:0]   cap_clamped;
  logic [TYPES_W-1:0] types_raw;
  logic [TYPES_W-1:0] types_clamped;

  assign d           = depth[tid_q];
  assign d_minus     = d - CAP_W'(1);
  assign push_en     = cmd.release_one | (cmd.walk_step & active_map[tid_q][walk_k]);
  assign push_idx    = cmd.release_one ? slot_q : walk_k;
  assign granted_val = pop_init ? d[SLOT_W-1:0] : ram_rdata;
  assign count_next  = capacity - depth_sel_next;

  always_comb begin
    if (cmd.pop) begin
      depth_sel_next = d_minus;
    end else if (push_en) begin
      depth_sel_next = d + CAP_W'(1);
    end else begin
      depth_sel_next = d;
    end
  end

  assign cap_raw   = cfg_data[CAP_W-1:0];
  assign types_raw = cfg_data[TYPES_W-1:0];

  always_comb begin
    if (cap_raw == '0) begin
      cap_clamped = CAP_W'(1);
    end else if (cap_raw > MAX_CAP) begin
      cap_clamped = MAX_CAP;
    end else begin
      cap_clamped = cap_raw;
    end
    types_clamped = (types_raw > MAX_TYPES) ? MAX_TYPES : types_raw;
  end

  always_comb begin
    stat.req          = ipfl_pkg::req_t'(req_q);
    stat.bad_type     = TYPES_W'(tid_q) >= types_defined;
    stat.empty        = d == '0;
    stat.out_of_range = CAP_W'(slot_q) >= capacity;
    stat.slot_active  = active_map[tid_q][slot_q];
    stat.walk_last    = CAP_W'(walk_k) == capacity - CAP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      types_defined <= '0;
      capacity      <= INIT_CAP;
      done          <= 1'b0;
      for (int p = 0; p < NUM_POOLS; p++) begin
        depth[p]      <= INIT_CAP;
        low_mark[p]   <= INIT_CAP;
        active_map[p] <= '0;
      end
    end else begin
      done <= cmd.emit;
      if (cfg_valid) begin
        case (cfg_index)
          ipfl_pkg::REG_TYPES: begin
            types_defined <= types_clamped;
          end
          ipfl_pkg::REG_CAPACITY: begin
            capacity <= cap_clamped;
            for (int p = 0; p < NUM_POOLS; p++) begin
              depth[p]      <= cap_clamped;
              low_mark[p]   <= cap_clamped;
              active_map[p] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.pop) begin
        depth[tid_q] <= d_minus;
        if (d_minus < low_mark[tid_q]) begin
          low_mark[tid_q] <= d_minus;
        end
      end
      if (push_en) begin
        depth[tid_q]                 <= d + CAP_W'(1);
        active_map[tid_q][push_idx]  <= 1'b0;
      end
      if (cmd.grant) begin
        active_map[tid_q][granted_val] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= req_type;
      tid_q  <= type_id;
      slot_q <= slot_index;
    end
    if (cmd.pop) begin
      pop_init <= d_minus < low_mark[tid_q];
    end
    if (cmd.walk_init) begin
      walk_k <= '0;
    end else if (cmd.walk_step) begin
      walk_k <= walk_k + SLOT_W'(1);
    end
    if (cmd.emit) begin
      status        <= cmd.emit_status;
      granted_index <= cmd.grant ? granted_val : '0;
      active_count  <= stat.bad_type ? '0 : count_next;
    end
  end

  ipfl_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (2 ** ADDR_W)
  ) u_stack_ram (
    .clk   (clk),
    .we    (push_en),
    .waddr ({tid_q, d[SLOT_W-1:0]}),
    .wdata (push_idx),
    .raddr ({tid_q, d_minus[SLOT_W-1:0]}),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

>>> design/indexed_pool_free_list_allocator.sv
// channel   signals                                      handshake
// --------  -------------------------------------------  ---------------------------
// request   req_type, type_id, slot_index                start & !busy
// result    status, granted_index, active_count          done, one cycle, no stall
// config    cfg_index, cfg_data                          cfg_valid & cfg_ready
//
// Query, release and every rejected request: EXEC emits the result, which is registered
// onto done and the outputs; the block then goes idle. Allocate adds a GRANT state, set
// by the registered read of the free-stack RAM. Release-all: WALK, one slot of the pool
// bitmap walked per cycle, with a push into the stack RAM for each active slot.
// Reset or a capacity write restores all pools at once in the registers; no clearing pass.
// cfg_ready is always high; done cannot be held off by the receiver.
`default_nettype none
module indexed_pool_free_list_allocator #(
  parameter  int NUM_POOLS  = ipfl_pkg::DEF_NUM_POOLS,
  parameter  int POOL_SLOTS = ipfl_pkg::DEF_POOL_SLOTS,
  localparam int SLOT_W     = $clog2(POOL_SLOTS),
  localparam int CAP_W      = $clog2(POOL_SLOTS + 1),
  localparam int TID_W      = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1,
  localparam int TYPES_W    = $clog2(NUM_POOLS + 1),
  localparam int CFG_W      = (TYPES_W > CAP_W) ? TYPES_W : CAP_W
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [ipfl_pkg::REQ_W-1:0]       req_type,
  input  wire logic [TID_W-1:0]                 type_id,
  input  wire logic [SLOT_W-1:0]                slot_index,
  output logic                                  done,
  output logic [ipfl_pkg::STATUS_W-1:0]         status,
  output logic [SLOT_W-1:0]                     granted_index,
  output logic [CAP_W-1:0]                      active_count,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ipfl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]                 cfg_data
);

  ipfl_pkg::ctl_cmd_t cmd;
  ipfl_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  ipfl_controller u_ctl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ipfl_datapath #(
    .NUM_POOLS  (NUM_POOLS),
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .type_id       (type_id),
    .slot_index    (slot_index),
    .cmd           (cmd),
    .stat          (stat),
    .done          (done),
    .status        (status),
    .granted_index (granted_index),
    .active_count  (active_count)
  );

endmodule
`default_nettype wire
